[src/seen_node_table_lru_assert.svh]
// Assertion macros shared by the seen-node table RTL.
`ifndef SEEN_NODE_TABLE_LRU_ASSERT_SVH
`define SEEN_NODE_TABLE_LRU_ASSERT_SVH

// The condition holds at every clock edge outside reset.
`define SNT_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define SNT_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define SNT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[src/snt_pkg.sv]
// Types, request codes and defaults of the seen-node table.
`default_nettype none
package snt_pkg;

   localparam int TABLE_ENTRIES_DEF = 16;

   localparam logic [1:0] REQ_UPDATE = 2'd0;
   localparam logic [1:0] REQ_READ   = 2'd1;
   localparam logic [1:0] REQ_CLEAR  = 2'd2;

   typedef struct packed {
      logic [1:0]         req_type;
      logic [7:0]         node_hash;
      logic signed [15:0] rssi_dbm;
      logic signed [7:0]  snr_db;
      logic [31:0]        now_ms;
      logic [3:0]         read_index;
   } snt_req_type;

   typedef struct packed {
      logic               is_new;
      logic               entry_valid;
      logic [3:0]         entry_slot;
      logic [7:0]         entry_hash;
      logic signed [15:0] entry_rssi;
      logic signed [7:0]  entry_snr;
      logic signed [7:0]  entry_snr_avg;
      logic [7:0]         entry_packet_count;
      logic [31:0]        entry_last_seen;
      logic [4:0]         node_count;
   } snt_rsp_type;

   typedef struct packed {
      logic [7:0]         hash;
      logic signed [15:0] rssi;
      logic signed [7:0]  snr;
      logic signed [7:0]  snr_avg;
      logic [7:0]         packet_count;
      logic [31:0]        last_seen;
   } snt_entry_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_READ,
      ST_WRITE
   } snt_state_type;

endpackage
`default_nettype wire

[src/seen_node_table_lru.sv]
// Seen-node table: neighbor entries keyed by node hash, oldest entry replaced when full.
// One request is taken when start is high and busy is low; exactly one result
// follows on rsp_data, marked by rsp_strobe for a single cycle, and it cannot be
// held off. The entries live in one synchronous memory with a registered read, and
// an update walks it one entry per cycle, then writes the matched, appended or
// replaced entry. A clear, a read past the fill count or an unknown request code
// is answered from idle with no memory access. busy drops in the cycle the result
// appears, so the next request can be transferred while that result is on the
// ports. Entries beyond the fill count are never read, so no clearing pass follows
// reset or clear.
`default_nettype none
`include "seen_node_table_lru_assert.svh"
module seen_node_table_lru #(
   parameter int TABLE_ENTRIES = snt_pkg::TABLE_ENTRIES_DEF
) (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       start,
   output logic                      busy,
   input  wire snt_pkg::snt_req_type req_data,
   output logic                      rsp_strobe,
   output snt_pkg::snt_rsp_type      rsp_data
);

   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

   snt_pkg::snt_entry_type entry_mem [TABLE_ENTRIES];
   snt_pkg::snt_entry_type rd_data_ff;
   logic [IDX_W-1:0]       rd_addr;
   logic                   mem_we;
   logic [IDX_W-1:0]       wr_addr;
   snt_pkg::snt_entry_type wr_data;

   snt_pkg::snt_state_type state_ff, state_in;
   snt_pkg::snt_req_type   req_ff, req_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [CNT_W-1:0]       issue_ff, issue_in;
   logic                   pend_ff, pend_in;
   logic [IDX_W-1:0]       pend_idx_ff, pend_idx_in;
   logic [IDX_W-1:0]       best_idx_ff, best_idx_in;
   logic [31:0]            best_time_ff, best_time_in;
   snt_pkg::snt_entry_type hit_ff, hit_in;
   logic                   found_ff, found_in;
   logic [IDX_W-1:0]       slot_ff, slot_in;
   logic                   rsp_strobe_ff, rsp_strobe_in;
   snt_pkg::snt_rsp_type   rsp_data_ff, rsp_data_in;

   logic [31:0]            count_wide;
   logic [31:0]            idx_wide;
   logic [31:0]            slot_wide;
   logic                   read_ok;
   logic                   match;
   logic                   older;
   logic signed [11:0]     avg_old;
   logic signed [11:0]     avg_snr;
   logic signed [11:0]     avg_sum;
   logic signed [11:0]     avg_adj;
   logic signed [11:0]     avg_quo;
   snt_pkg::snt_entry_type new_entry;

   // Entry memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         entry_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= entry_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= snt_pkg::ST_IDLE;
         count_ff      <= '0;
         pend_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         pend_ff       <= pend_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      issue_ff     <= issue_in;
      pend_idx_ff  <= pend_idx_in;
      best_idx_ff  <= best_idx_in;
      best_time_ff <= best_time_in;
      hit_ff       <= hit_in;
      found_ff     <= found_in;
      slot_ff      <= slot_in;
      rsp_data_ff  <= rsp_data_in;
   end

   always_comb begin
      count_wide = 32'(count_ff);
      idx_wide   = 32'(req_data.read_index);
      slot_wide  = 32'(slot_ff);
      read_ok    = idx_wide < count_wide;
      match      = pend_ff && (rd_data_ff.hash == req_ff.node_hash);
      // The first entry seeds the oldest search; later ones win only when strictly older.
      older      = pend_ff && ((pend_idx_ff == '0) || (rd_data_ff.last_seen < best_time_ff));

      // Running average (avg*7 + snr)/8, rounded toward zero.
      avg_old = 12'(hit_ff.snr_avg);
      avg_snr = 12'(req_ff.snr_db);
      avg_sum = (avg_old <<< 3) - avg_old + avg_snr;
      avg_adj = avg_sum[11] ? (avg_sum + 12'sd7) : avg_sum;
      avg_quo = avg_adj >>> 3;

      new_entry.hash      = req_ff.node_hash;
      new_entry.rssi      = req_ff.rssi_dbm;
      new_entry.snr       = req_ff.snr_db;
      new_entry.last_seen = req_ff.now_ms;
      if (found_ff) begin
         new_entry.snr_avg      = avg_quo[7:0];
         new_entry.packet_count = (hit_ff.packet_count == 8'hFF) ? 8'hFF
                                                                 : hit_ff.packet_count + 8'd1;
      end else begin
         new_entry.snr_avg      = req_ff.snr_db;
         new_entry.packet_count = 8'd1;
      end
   end

   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      count_in      = count_ff;
      issue_in      = issue_ff;
      pend_in       = 1'b0;
      pend_idx_in   = pend_idx_ff;
      best_idx_in   = best_idx_ff;
      best_time_in  = best_time_ff;
      hit_in        = hit_ff;
      found_in      = found_ff;
      slot_in       = slot_ff;
      rsp_strobe_in = 1'b0;
      rsp_data_in   = rsp_data_ff;
      rd_addr       = issue_ff[IDX_W-1:0];
      mem_we        = 1'b0;
      wr_addr       = slot_ff;
      wr_data       = new_entry;

      unique case (state_ff)
         snt_pkg::ST_IDLE: begin
            if (start) begin
               req_in   = req_data;
               issue_in = '0;
               found_in = 1'b0;
               unique case (req_data.req_type)
                  snt_pkg::REQ_UPDATE: begin
                     state_in = snt_pkg::ST_SCAN;
                  end
                  snt_pkg::REQ_READ: begin
                     if (read_ok) begin
                        rd_addr  = idx_wide[IDX_W-1:0];
                        state_in = snt_pkg::ST_READ;
                     end else begin
                        rsp_data_in            = '0;
                        rsp_data_in.node_count = count_wide[4:0];
                        rsp_strobe_in          = 1'b1;
                     end
                  end
                  snt_pkg::REQ_CLEAR: begin
                     count_in      = '0;
                     rsp_data_in   = '0;
                     rsp_strobe_in = 1'b1;
                  end
                  default: begin
                     rsp_data_in            = '0;
                     rsp_data_in.node_count = count_wide[4:0];
                     rsp_strobe_in          = 1'b1;
                  end
               endcase
            end
         end

         snt_pkg::ST_SCAN: begin
            if (match) begin
               hit_in   = rd_data_ff;
               slot_in  = pend_idx_ff;
               found_in = 1'b1;
               state_in = snt_pkg::ST_WRITE;
            end else begin
               if (older) begin
                  best_idx_in  = pend_idx_ff;
                  best_time_in = rd_data_ff.last_seen;
               end
               if (issue_ff < count_ff) begin
                  rd_addr     = issue_ff[IDX_W-1:0];
                  pend_in     = 1'b1;
                  pend_idx_in = issue_ff[IDX_W-1:0];
                  issue_in    = issue_ff + 1'b1;
               end else begin
                  // Walk finished without a hit: append, or replace the oldest entry.
                  state_in = snt_pkg::ST_WRITE;
                  if (count_ff < CNT_W'(TABLE_ENTRIES)) begin
                     slot_in  = count_ff[IDX_W-1:0];
                     count_in = count_ff + 1'b1;
                  end else begin
                     slot_in = older ? pend_idx_ff : best_idx_ff;
                  end
               end
            end
         end

         snt_pkg::ST_WRITE: begin
            mem_we                         = 1'b1;
            rsp_data_in.is_new             = !found_ff;
            rsp_data_in.entry_valid        = 1'b1;
            rsp_data_in.entry_slot         = slot_wide[3:0];
            rsp_data_in.entry_hash         = new_entry.hash;
            rsp_data_in.entry_rssi         = new_entry.rssi;
            rsp_data_in.entry_snr          = new_entry.snr;
            rsp_data_in.entry_snr_avg      = new_entry.snr_avg;
            rsp_data_in.entry_packet_count = new_entry.packet_count;
            rsp_data_in.entry_last_seen    = new_entry.last_seen;
            rsp_data_in.node_count         = count_wide[4:0];
            rsp_strobe_in                  = 1'b1;
            state_in                       = snt_pkg::ST_IDLE;
         end

         snt_pkg::ST_READ: begin
            rsp_data_in.is_new             = 1'b0;
            rsp_data_in.entry_valid        = 1'b1;
            rsp_data_in.entry_slot         = req_ff.read_index;
            rsp_data_in.entry_hash         = rd_data_ff.hash;
            rsp_data_in.entry_rssi         = rd_data_ff.rssi;
            rsp_data_in.entry_snr          = rd_data_ff.snr;
            rsp_data_in.entry_snr_avg      = rd_data_ff.snr_avg;
            rsp_data_in.entry_packet_count = rd_data_ff.packet_count;
            rsp_data_in.entry_last_seen    = rd_data_ff.last_seen;
            rsp_data_in.node_count         = count_wide[4:0];
            rsp_strobe_in                  = 1'b1;
            state_in                       = snt_pkg::ST_IDLE;
         end

         default: begin
            state_in = snt_pkg::ST_IDLE;
         end
      endcase
   end

   assign busy       = (state_ff != snt_pkg::ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

   `SNT_ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CNT_W'(TABLE_ENTRIES), "fill count exceeds table size")
   `SNT_ASSERT_IMPLIES(a_scan_bound, clock, reset, state_ff == snt_pkg::ST_SCAN, issue_ff <= count_ff, "scan index ran past fill count")
   `SNT_ASSERT_NEXT(a_write_strobe, clock, reset, state_ff == snt_pkg::ST_WRITE, rsp_strobe, "update finished without a result")
   `SNT_ASSERT_NEXT(a_accept_progress, clock, reset, start && !busy, busy || rsp_strobe, "accepted request neither busy nor answered")
   `SNT_ASSERT_IMPLIES(a_invalid_not_new, clock, reset, rsp_strobe && !rsp_data.entry_valid, !rsp_data.is_new, "empty result marked as new")

endmodule
`default_nettype wire
